// ----- rtl/lps_pkg.sv -----
`timescale 1ns / 1ps

package lps_pkg;

  localparam int OP_BITS   = 2;
  localparam int POS_BITS  = 4;
  localparam int VAL_BITS  = 8;
  localparam int LEN_BITS  = 5;
  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(16);

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD = 2'd0,
    OP_NEXT = 2'd1,
    OP_PREV = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_BITS-1:0]  operation;
    logic [POS_BITS-1:0] position;
    logic [VAL_BITS-1:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic [POS_BITS-1:0] out_position;
    logic [VAL_BITS-1:0] out_value;
    logic                wrapped;
    logic                last_of_run;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_HEAD,
    ST_SCAN,
    ST_PART,
    ST_SWAP_PIV,
    ST_SWAP_PTR,
    ST_REV_LO,
    ST_REV_HI,
    ST_REV_WR_LO,
    ST_REV_WR_HI,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/lexicographic_permutation_stepper.sv -----
`timescale 1ns / 1ps
// sequence: a load word gives no result; a step word scans for the ascent (pivot), finds
//   the partner, swaps the two, reverses the tail (the whole run on a wrap, which skips
//   partner and swap), then gives n results on consecutive cycles (n = active length)
// throughput: one step at a time, one read and one write of the element memory per cycle
// reset: length returns to 16 and every element i reads as i+1 until written again
// results are strobed for one cycle each; the receiver cannot stall them
module lexicographic_permutation_stepper
  import lps_pkg::*;
#(
  parameter int MAX_LENGTH = 16,
  parameter int VALUE_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  in_word_t            request,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LEN_BITS-1:0] cfg_data,
  output logic                result_valid,
  output out_word_t           result
);

  // address width of the element memory
  localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  // width that holds a length up to MAX_LENGTH and the 5-bit register
  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int CW = (LW > LEN_BITS) ? LW : LEN_BITS;
  // widths for identity value, load value and emitted value conversions
  localparam int XW = ((AW + 1) > VALUE_BITS) ? (AW + 1) : VALUE_BITS;
  localparam int EW = (VAL_BITS > VALUE_BITS) ? VAL_BITS : VALUE_BITS;
  localparam int PW = (POS_BITS > AW) ? POS_BITS : AW;

  // ---------------------------------------------------------------------------
  // control and datapath registers
  // ---------------------------------------------------------------------------
  state_t                state, state_next;
  logic [LEN_BITS-1:0]   len_reg;
  logic [AW-1:0]         n_last, n_last_next;     // index of last active element
  logic                  fwd, fwd_next;           // step direction
  logic                  wrap, wrap_next;
  logic [AW-1:0]         k, k_next;               // scan / partner / emit index
  logic [AW-1:0]         pivot, pivot_next;
  logic [AW-1:0]         partner, partner_next;
  logic [VALUE_BITS-1:0] b_val, b_val_next;       // right neighbor during scan
  logic [VALUE_BITS-1:0] pval, pval_next;         // pivot value
  logic [VALUE_BITS-1:0] part_val, part_val_next; // partner value
  logic [AW-1:0]         lo, lo_next;
  logic [AW-1:0]         hi, hi_next;
  logic [VALUE_BITS-1:0] t_lo, t_lo_next;

  // ---------------------------------------------------------------------------
  // element memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [VALUE_BITS-1:0] mem [MAX_LENGTH];
  logic [MAX_LENGTH-1:0] vld;                     // entry written since reset
  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [VALUE_BITS-1:0] mem_q;
  logic                  q_vld;
  logic [AW-1:0]         q_addr;
  logic [XW-1:0]         ident;
  logic [VALUE_BITS-1:0] rd_val;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q  <= mem[rd_addr];
    q_addr <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      // a write in the same cycle lands after the read, matching the array
      q_vld <= vld[rd_addr];
    end
  end

  // never-written entries read as their reset identity value
  assign ident  = XW'(q_addr) + XW'(1);
  assign rd_val = q_vld ? mem_q : ident[VALUE_BITS-1:0];

  // ---------------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------------
  logic                  accept;
  logic [CW-1:0]         len_ext;
  logic [CW-1:0]         n_act;
  logic [CW-1:0]         n_act_m1;
  logic [CW-1:0]         pos_ext;
  logic                  pos_ok;
  logic [EW-1:0]         load_ext;

  assign accept   = start && !busy;
  assign len_ext  = CW'(len_reg);
  // zero counts as one, oversize saturates
  assign n_act    = (len_ext == '0) ? CW'(1) :
                    (len_ext > CW'(MAX_LENGTH)) ? CW'(MAX_LENGTH) : len_ext;
  assign n_act_m1 = n_act - CW'(1);
  assign pos_ext  = CW'(request.position);
  assign pos_ok   = pos_ext < CW'(MAX_LENGTH);
  assign load_ext = EW'(request.element_value);

  // ---------------------------------------------------------------------------
  // comparators: strict order in the step direction
  // ---------------------------------------------------------------------------
  logic scan_hit;   // ascent (descent) between rd_val at k-1 and b_val at k
  logic part_hit;   // rd_val beyond pivot value in the step direction

  assign scan_hit = fwd ? (rd_val < b_val) : (rd_val > b_val);
  assign part_hit = fwd ? (rd_val > pval)  : (rd_val < pval);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next    = state;
    n_last_next   = n_last;
    fwd_next      = fwd;
    wrap_next     = wrap;
    k_next        = k;
    pivot_next    = pivot;
    partner_next  = partner;
    b_val_next    = b_val;
    pval_next     = pval;
    part_val_next = part_val;
    lo_next       = lo;
    hi_next       = hi;
    t_lo_next     = t_lo;
    rd_addr       = k;
    we            = 1'b0;
    waddr         = lo;
    wdata         = rd_val;

    unique case (state)
      ST_IDLE: begin
        rd_addr = n_act_m1[AW-1:0];
        if (accept) begin
          case (request.operation)
            OP_LOAD: begin
              // loads beyond the store are dropped
              we    = pos_ok;
              waddr = pos_ext[AW-1:0];
              wdata = load_ext[VALUE_BITS-1:0];
            end
            OP_NEXT, OP_PREV: begin
              fwd_next    = (request.operation == OP_NEXT);
              n_last_next = n_act_m1[AW-1:0];
              k_next      = n_act_m1[AW-1:0];
              if (n_act == CW'(1)) begin
                // lone element: nothing to step, flag the wrap and emit it
                wrap_next  = 1'b1;
                state_next = ST_EMIT;
              end else begin
                wrap_next  = 1'b0;
                state_next = ST_SCAN_HEAD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN_HEAD: begin
        b_val_next = rd_val;
        rd_addr    = k - AW'(1);
        state_next = ST_SCAN;
      end

      ST_SCAN: begin
        // rd_val holds element k-1
        if (scan_hit) begin
          pivot_next = k - AW'(1);
          pval_next  = rd_val;
          rd_addr    = n_last;
          k_next     = n_last;
          state_next = ST_PART;
        end else if (k == AW'(1)) begin
          // no ascent: reverse the whole active run
          wrap_next  = 1'b1;
          lo_next    = '0;
          hi_next    = n_last;
          state_next = ST_REV_LO;
        end else begin
          b_val_next = rd_val;
          k_next     = k - AW'(1);
          rd_addr    = k - AW'(2);
        end
      end

      ST_PART: begin
        // rightmost element past the pivot that beats it; pivot+1 always does
        if (part_hit) begin
          partner_next  = k;
          part_val_next = rd_val;
          state_next    = ST_SWAP_PIV;
        end else begin
          k_next  = k - AW'(1);
          rd_addr = k - AW'(1);
        end
      end

      ST_SWAP_PIV: begin
        we    = 1'b1;
        waddr = pivot;
        wdata = part_val;
        state_next = ST_SWAP_PTR;
      end

      ST_SWAP_PTR: begin
        we      = 1'b1;
        waddr   = partner;
        wdata   = pval;
        lo_next = pivot + AW'(1);
        hi_next = n_last;
        if ((n_last - pivot) > AW'(1)) begin
          state_next = ST_REV_LO;
        end else begin
          // partner is above zero, so reading element zero sees no pending write
          rd_addr    = '0;
          k_next     = '0;
          state_next = ST_EMIT;
        end
      end

      ST_REV_LO: begin
        rd_addr    = lo;
        state_next = ST_REV_HI;
      end

      ST_REV_HI: begin
        t_lo_next  = rd_val;
        rd_addr    = hi;
        state_next = ST_REV_WR_LO;
      end

      ST_REV_WR_LO: begin
        we         = 1'b1;
        waddr      = lo;
        wdata      = rd_val;
        state_next = ST_REV_WR_HI;
      end

      ST_REV_WR_HI: begin
        we      = 1'b1;
        waddr   = hi;
        wdata   = t_lo;
        lo_next = lo + AW'(1);
        hi_next = hi - AW'(1);
        if (((AW+1)'(hi) - (AW+1)'(lo)) > (AW+1)'(2)) begin
          // next low element is not the one being written now
          rd_addr    = lo + AW'(1);
          state_next = ST_REV_HI;
        end else begin
          rd_addr    = '0;
          k_next     = '0;
          state_next = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // rd_val holds element k
        if (k == n_last) begin
          state_next = ST_IDLE;
        end else begin
          k_next  = k + AW'(1);
          rd_addr = k + AW'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      len_reg <= LEN_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        len_reg <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_last   <= n_last_next;
    fwd      <= fwd_next;
    wrap     <= wrap_next;
    k        <= k_next;
    pivot    <= pivot_next;
    partner  <= partner_next;
    b_val    <= b_val_next;
    pval     <= pval_next;
    part_val <= part_val_next;
    lo       <= lo_next;
    hi       <= hi_next;
    t_lo     <= t_lo_next;
  end

  // ---------------------------------------------------------------------------
  // result word register: one word per active element, in index order
  // ---------------------------------------------------------------------------
  logic [PW-1:0] pos_out_ext;
  logic [EW-1:0] val_out_ext;

  assign pos_out_ext = PW'(k);
  assign val_out_ext = EW'(rd_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    result.out_position <= pos_out_ext[POS_BITS-1:0];
    result.out_value    <= val_out_ext[VAL_BITS-1:0];
    result.wrapped      <= wrap;
    result.last_of_run  <= (k == n_last);
  end

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ST_EMIT)
    else $error("result word without an emit cycle");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_of_run) |=> !result_valid)
    else $error("result word follows the end of a run");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (k != '0))
    else $error("ascent scan ran past element zero");

  a_partner_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PART) |-> (k > pivot))
    else $error("partner search reached the pivot");

  a_rev_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REV_LO || state == ST_REV_HI) |-> (lo < hi))
    else $error("tail reversal with crossed bounds");

endmodule
